@@ hdl/lldts_pkg.sv @@
package lldts_pkg;

  // Table geometry
  localparam int MAX_DEFS  = 256;
  localparam int IDX_W     = $clog2(MAX_DEFS);
  localparam int CNT_W     = $clog2(MAX_DEFS + 1);

  // Field widths
  localparam int NUM_W     = 16;
  localparam int SEC_W     = 8;
  localparam int OFF_W     = 32;

  typedef enum logic [0:0] {
    CMD_ADD     = 1'b0,
    CMD_RESOLVE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [NUM_W-1:0] number;
    logic [SEC_W-1:0] section;
    logic [OFF_W-1:0] offset;
  } def_entry_t;

  // Controller to datapath
  typedef struct packed {
    logic latch_in;
    logic start;
    logic scan_step;
    logic load_out;
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic is_add;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

@@ hdl/lldts_ctrl.sv @@
module lldts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lldts_pkg::sts_t   sts,
  output lldts_pkg::ctl_t   ctl
);
  import lldts_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = sts.is_add ? ST_FINISH : ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready     = 1'b1;
        ctl.latch_in = in_valid;
      end
      ST_EXEC: begin
        ctl.start = 1'b1;
      end
      ST_SCAN: begin
        ctl.scan_step = 1'b1;
      end
      ST_FINISH: begin
        ctl.load_out = sts.out_free;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

endmodule

@@ hdl/lldts_dp.sv @@
module lldts_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  lldts_pkg::ctl_t                ctl,
  output lldts_pkg::sts_t                sts,
  input  logic                           cmd,
  input  logic [lldts_pkg::NUM_W-1:0]    label_number,
  input  logic [lldts_pkg::SEC_W-1:0]    section_index,
  input  logic [lldts_pkg::OFF_W-1:0]    byte_offset,
  input  logic                           search_forward,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           found,
  output logic [lldts_pkg::OFF_W-1:0]    target_offset,
  output logic                           table_full
);
  import lldts_pkg::*;

  // Held request word
  cmd_t             q_cmd;
  logic [NUM_W-1:0] q_num;
  logic [SEC_W-1:0] q_sec;
  logic [OFF_W-1:0] q_off;
  logic             q_fwd;

  // Table storage
  def_entry_t       mem [MAX_DEFS];
  logic [CNT_W-1:0] def_count;
  def_entry_t       rd_data;

  // Scan state
  logic [IDX_W-1:0] scan_addr;
  logic [CNT_W-1:0] scan_left;
  logic             pending;

  // Result registers
  logic             res_hit;
  logic [OFF_W-1:0] res_target;
  logic             res_full;

  logic             is_full;
  logic [CNT_W-1:0] cnt_minus1;
  logic             key_eq;
  logic             off_ok;
  logic             match_now;
  logic             issue;

  assign is_full    = (def_count == CNT_W'(MAX_DEFS));
  assign cnt_minus1 = def_count - CNT_W'(1);
  assign key_eq     = (rd_data.number == q_num) && (rd_data.section == q_sec);
  assign off_ok     = q_fwd ? (rd_data.offset >= q_off) : (rd_data.offset <= q_off);
  assign match_now  = pending && key_eq && off_ok;
  assign issue      = ctl.scan_step && (scan_left != '0);

  assign sts.is_add    = (q_cmd == CMD_ADD);
  assign sts.scan_done = match_now || (!pending && (scan_left == '0));
  assign sts.out_free  = !out_valid || out_ready;

  // Capture the request word on accept
  always_ff @(posedge clk) begin
    if (ctl.latch_in) begin
      q_cmd <= cmd_t'(cmd);
      q_num <= label_number;
      q_sec <= section_index;
      q_off <= byte_offset;
      q_fwd <= search_forward;
    end
  end

  // Append a definition
  always_ff @(posedge clk) begin
    if (ctl.start && (q_cmd == CMD_ADD) && !is_full) begin
      mem[def_count[IDX_W-1:0]] <= '{number: q_num, section: q_sec, offset: q_off};
    end
  end

  // Registered table read for the scan
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[scan_addr];
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      def_count <= '0;
    end else if (ctl.start && (q_cmd == CMD_ADD) && !is_full) begin
      def_count <= def_count + CNT_W'(1);
    end
  end

  // Scan address walk: up from the oldest entry, or down from the newest
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_left <= '0;
      pending   <= 1'b0;
    end else if (ctl.start) begin
      scan_left <= (q_cmd == CMD_RESOLVE) ? def_count : '0;
      pending   <= 1'b0;
    end else if (ctl.scan_step) begin
      pending <= issue;
      if (issue) scan_left <= scan_left - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      scan_addr <= q_fwd ? '0 : cnt_minus1[IDX_W-1:0];
    end else if (issue) begin
      scan_addr <= q_fwd ? scan_addr + IDX_W'(1) : scan_addr - IDX_W'(1);
    end
  end

  // Result of the current command
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      res_hit    <= 1'b0;
      res_target <= '0;
      res_full   <= (q_cmd == CMD_ADD) && is_full;
    end else if (ctl.scan_step && match_now) begin
      res_hit    <= 1'b1;
      res_target <= rd_data.offset;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      found         <= res_hit;
      target_offset <= res_target;
      table_full    <= res_full;
    end
  end

endmodule

@@ hdl/local_label_def_table_search.sv @@
// Chan | Handshake            | Fields
// -----+----------------------+-------------------------------------------------------------
// in   | in_valid / in_ready  | cmd, label_number, section_index, byte_offset, search_forward
// out  | out_valid / out_ready| found, target_offset, table_full
//
// One word is in flight at a time. An add goes from ST_EXEC to ST_FINISH,
// which loads the output register and raises out_valid once it is free; a
// resolve walks the table one entry per cycle through the single registered
// read port and stops early when an entry matches. The next word is accepted
// the cycle after the result is loaded.
// rst clears the entry count and the handshakes; the table itself holds
// stale data that is never read. A result waiting on out_ready does not
// block the next input word, only the hand-off of the next result.
module local_label_def_table_search (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         cmd,
  input  logic [lldts_pkg::NUM_W-1:0]  label_number,
  input  logic [lldts_pkg::SEC_W-1:0]  section_index,
  input  logic [lldts_pkg::OFF_W-1:0]  byte_offset,
  input  logic                         search_forward,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         found,
  output logic [lldts_pkg::OFF_W-1:0]  target_offset,
  output logic                         table_full
);
  import lldts_pkg::*;

  ctl_t ctl;
  sts_t sts;

  lldts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  lldts_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .sts            (sts),
    .cmd            (cmd),
    .label_number   (label_number),
    .section_index  (section_index),
    .byte_offset    (byte_offset),
    .search_forward (search_forward),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .found          (found),
    .target_offset  (target_offset),
    .table_full     (table_full)
  );

endmodule
